// ===== rtl/gwh_pkg.sv =====
// shared types and constants for the groundwater head stencil update
// line buffer word layouts, register indexes and the control state type
// no dependencies
package gwh_pkg;

  localparam int MAX_COLS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);

  // configuration register indexes
  localparam logic [1:0] CFG_THICKNESS = 2'd0;
  localparam logic [1:0] CFG_TIME_AREA = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;
  localparam logic [1:0] CFG_COLS      = 2'd3;

  // stencil neighbor slots, in the order they are summed
  localparam logic [1:0] NB_UP    = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_DOWN  = 2'd2;
  localparam logic [1:0] NB_RIGHT = 2'd3;

  // row above keeps head and conductivity
  typedef struct packed {
    logic [31:0] cond;
    logic [31:0] head;
  } above_word_t;

  // center row keeps every input field
  typedef struct packed {
    logic [31:0] src;
    logic [15:0] yld;
    logic [31:0] cond;
    logic [31:0] head;
  } center_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_TK,
    ST_TD,
    ST_TACC,
    ST_SLO,
    ST_SHI,
    ST_SSUM,
    ST_DCHK,
    ST_DIV,
    ST_FIN,
    ST_EMIT1,
    ST_EMIT2
  } gwh_state_t;

endpackage

// ===== rtl/gwh_div.sv =====
// serial restoring divider, one quotient bit per cycle
// divides {rem_init, dividend} by a 16 bit divisor, rem_init below divisor
// depends on gwh_pkg only by convention (no shared items used)
module gwh_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] dividend,
  input  logic [15:0] rem_init,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [33:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dsr_r, dsr_nxt;
  logic [33:0] dvd_r, dvd_nxt;
  logic [33:0] quo_r, quo_nxt;
  logic [16:0] trial;
  logic        fits;

  // one shift and trial subtract
  assign trial = {rem_r, dvd_r[33]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = rem_init;
      dsr_nxt  = divisor;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? 16'(trial - {1'b0, dsr_r}) : trial[15:0];
      quo_nxt = {quo_r[32:0], fits};
      dvd_nxt = {dvd_r[32:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd33) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |=> (busy_r || done_r))
    else $error("divider stopped without done");
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |-> rem_r < dsr_r)
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/groundwater_head_stencil_update.sv =====
// top level of the groundwater head stencil update: line buffers, sequencer,
// shared multiplier and result register
// depends on gwh_pkg and gwh_div
//
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | in_tdata: cell_head, conductivity,
//         |     |                        |   specific_yield, source_flow
// out_    | out | out_tvalid / out_tready| out_tdata: head_out; out_tlast:
//         |     |                        |   last_of_run; out_tuser
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// after reset a clearing pass over all 1024 entries zeroes both line buffers; no beat
// is accepted meanwhile. one item at a time: pass-through rows skip the arithmetic,
// an updated cell uses the shared 33x32 multiplier (two products per neighbor,
// two for the scaling) and, unless its change is capped, the 34 step divider.
// a finished result waits in the output register while the next beat is taken.
module groundwater_head_stencil_update
  import gwh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // cell_head, conductivity, specific_yield, source_flow
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // head_out
  output logic         out_tlast,
  output logic [1:0]   out_tuser,  // yield_fault, frame_end
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  gwh_state_t state_r, state_nxt;

  // configuration
  logic [31:0] thickness_r, time_area_r;
  logic [15:0] rows_r;
  logic [10:0] cols_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thickness_r <= 32'd65536;
      time_area_r <= 32'd65536;
      rows_r      <= 16'd1024;
      cols_r      <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THICKNESS: thickness_r <= cfg_data;
        CFG_TIME_AREA: time_area_r <= cfg_data;
        CFG_ROWS:      rows_r      <= cfg_data[15:0];
        CFG_COLS:      cols_r      <= cfg_data[10:0];
        default:       ;
      endcase
    end
  end

  // position counters
  logic [15:0]      row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;
  logic [COL_W-1:0] clr_cnt_r;
  logic [15:0]      rows_eff;
  logic [10:0]      cols_eff;
  logic             at_last_row, at_last_col;

  assign rows_eff = (rows_r < 16'd3) ? 16'd3 : rows_r;
  assign cols_eff = (cols_r == 11'd0) ? 11'd1 :
                    ((cols_r > 11'(MAX_COLS)) ? 11'(MAX_COLS) : cols_r);
  assign at_last_row = row_cnt_r >= rows_eff - 16'd1;
  assign at_last_col = {1'b0, col_cnt_r} >= cols_eff - 11'd1;

  logic accept;
  assign accept = in_tvalid && in_tready;

  // item registers
  center_word_t in_w_r;
  logic         row0_r, row1_r, last_row_r, last_col_r, col0_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_w_r     <= center_word_t'(in_tdata);
      row0_r     <= row_cnt_r == 16'd0;
      row1_r     <= row_cnt_r == 16'd1;
      last_row_r <= at_last_row;
      last_col_r <= at_last_col;
      col0_r     <= col_cnt_r == '0;
    end
  end

  // line buffers
  above_word_t  above_mem  [MAX_COLS];
  center_word_t center_mem [MAX_COLS];
  above_word_t  above_rd_r;
  center_word_t center_rd0_r, center_rd1_r;
  logic             mem_we;
  logic [COL_W-1:0] wr_addr;
  above_word_t      above_wd;
  center_word_t     center_wd;

  assign wr_addr   = (state_r == ST_CLEAR) ? clr_cnt_r : col_cnt_r;
  assign above_wd  = (state_r == ST_CLEAR) ? '0 :
                     above_word_t'{cond: center_rd0_r.cond, head: center_rd0_r.head};
  assign center_wd = (state_r == ST_CLEAR) ? '0 : in_w_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      above_mem[wr_addr]  <= above_wd;
      center_mem[wr_addr] <= center_wd;
    end
    above_rd_r   <= above_mem[col_cnt_r];
    center_rd0_r <= center_mem[col_cnt_r];
    center_rd1_r <= center_mem[col_cnt_r + COL_W'(1)];
  end

  // neighbor work registers
  logic [31:0] nb_h_r [4];
  logic [31:0] nb_k_r [4];
  logic [31:0] prev_h_r, prev_k_r;
  logic [31:0] h_c_r;
  logic [15:0] y_c_r;
  logic [1:0]  idx_r, idx_nxt;
  logic        more_terms;

  always_comb begin
    idx_nxt = idx_r + 2'd1;
    if (idx_nxt == NB_LEFT && col0_r) idx_nxt = NB_DOWN;
  end
  assign more_terms = !(idx_r == NB_RIGHT || (idx_nxt == NB_RIGHT && last_col_r));

  // shared multiplier
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod_r;
  logic signed [32:0] diff;
  logic [32:0] diff_mag;
  logic signed [53:0] q_r;
  logic [52:0] a_mag;
  logic [63:0] lo_r;
  logic [84:0] p_r;

  assign diff     = 33'(signed'(nb_h_r[idx_r])) - 33'(signed'(h_c_r));
  assign diff_mag = diff[32] ? 33'(-diff) : diff;
  assign a_mag    = q_r[53] ? 53'(-q_r) : 53'(q_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_TK:  begin mul_a = {1'b0, nb_k_r[idx_r]}; mul_b = thickness_r; end
      ST_TD:  begin mul_a = diff_mag; mul_b = prod_r[63:32]; end
      ST_SLO: begin mul_a = {1'b0, a_mag[31:0]}; mul_b = time_area_r; end
      ST_SHI: begin mul_a = {12'd0, a_mag[52:32]}; mul_b = time_area_r; end
      default: ;
    endcase
  end

  // divider
  logic        div_start, div_done, cap_r;
  logic [33:0] quo;

  gwh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (p_r[33:0]),
    .rem_init (p_r[49:34]),
    .divisor  (y_c_r),
    .done     (div_done),
    .quotient (quo)
  );

  // new head from the scaled change
  logic [33:0]        chg;
  logic signed [35:0] nh;
  logic [31:0]        nh_sat;

  assign chg = (cap_r || quo > 34'h200000000) ? 34'h200000000 : quo;
  assign nh  = q_r[53] ? 36'(signed'(h_c_r)) - 36'(chg) : 36'(signed'(h_c_r)) + 36'(chg);
  assign nh_sat = (nh > 36'sh07FFFFFFF) ? 32'h7FFFFFFF :
                  ((nh < -36'sh080000000) ? 32'h80000000 : nh[31:0]);

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_LOAD: begin
        nb_h_r[NB_UP]    <= above_rd_r.head;
        nb_k_r[NB_UP]    <= above_rd_r.cond;
        nb_h_r[NB_LEFT]  <= prev_h_r;
        nb_k_r[NB_LEFT]  <= prev_k_r;
        nb_h_r[NB_DOWN]  <= in_w_r.head;
        nb_k_r[NB_DOWN]  <= in_w_r.cond;
        nb_h_r[NB_RIGHT] <= center_rd1_r.head;
        nb_k_r[NB_RIGHT] <= center_rd1_r.cond;
        prev_h_r <= center_rd0_r.head;
        prev_k_r <= center_rd0_r.cond;
        h_c_r    <= center_rd0_r.head;
        y_c_r    <= center_rd0_r.yld;
        q_r      <= -54'(signed'(center_rd0_r.src));
        idx_r    <= NB_UP;
      end
      ST_TACC: begin
        q_r   <= diff[32] ? q_r - 54'(prod_r[64:16]) : q_r + 54'(prod_r[64:16]);
        idx_r <= idx_nxt;
      end
      ST_SHI:  lo_r <= prod_r[63:0];
      ST_SSUM: p_r  <= {prod_r[52:0], 32'd0} + 85'(lo_r);
      ST_DCHK: cap_r <= p_r[84:34] >= 51'(y_c_r);
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == COL_W'(MAX_COLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (row0_r) state_nxt = ST_EMIT1;
        else if (row1_r) state_nxt = ST_IDLE;
        else if (center_rd0_r.yld == 16'd0) state_nxt = ST_EMIT1;
        else state_nxt = ST_TK;
      end
      ST_TK:   state_nxt = ST_TD;
      ST_TD:   state_nxt = ST_TACC;
      ST_TACC: state_nxt = more_terms ? ST_TK : ST_SLO;
      ST_SLO:  state_nxt = ST_SHI;
      ST_SHI:  state_nxt = ST_SSUM;
      ST_SSUM: state_nxt = ST_DCHK;
      ST_DCHK: state_nxt = (p_r[84:34] >= 51'(y_c_r)) ? ST_FIN : ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_EMIT1;
      ST_EMIT1: if (!out_tvalid || out_tready)
                  state_nxt = (!row0_r && last_row_r) ? ST_EMIT2 : ST_IDLE;
      ST_EMIT2: if (!out_tvalid || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  in_tready = 1'b1;
      ST_LOAD:  mem_we = 1'b1;
      ST_DCHK:  div_start = p_r[84:34] < 51'(y_c_r);
      default: ;
    endcase
  end

  // result one, held from load or finish
  logic [31:0] res_h_r;
  logic        res_f_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      res_h_r <= row0_r ? in_w_r.head : center_rd0_r.head;
      res_f_r <= !row0_r && center_rd0_r.yld == 16'd0;
    end else if (state_r == ST_FIN) begin
      res_h_r <= nh_sat;
      res_f_r <= 1'b0;
    end
  end

  // output register
  logic        out_tvalid_r;
  logic [31:0] out_head_r;
  logic        out_last_r, out_fault_r, out_fend_r;
  logic        load_out;

  assign load_out = (state_r == ST_EMIT1 || state_r == ST_EMIT2) &&
                    (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state_r == ST_EMIT1) begin
        out_head_r  <= res_h_r;
        out_fault_r <= res_f_r;
        out_last_r  <= row0_r || !last_row_r;
        out_fend_r  <= 1'b0;
      end else begin
        out_head_r  <= in_w_r.head;
        out_fault_r <= 1'b0;
        out_last_r  <= 1'b1;
        out_fend_r  <= last_col_r;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_head_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_fend_r, out_fault_r};

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + COL_W'(1);
      if (state_r == ST_LOAD) begin
        if (last_col_r) begin
          col_cnt_r <= '0;
          row_cnt_r <= last_row_r ? 16'd0 : row_cnt_r + 16'd1;
        end else begin
          col_cnt_r <= col_cnt_r + COL_W'(1);
        end
      end
    end
  end

  a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input beat taken during clearing pass");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_EMIT1 || state_r == ST_EMIT2))
    else $error("result beat raised outside an emit step");

endmodule

// ===== verif/tb_top.sv =====
// testbench for the groundwater head stencil update: drives raster-order cell beats,
// writes the registers between phases and checks every result beat against a predictor
// depends on gwh_pkg and the groundwater_head_stencil_update top level
`timescale 1ns / 1ps

// one expected result beat
typedef struct {
  bit [31:0] head;
  bit        fault;
  bit        last;
  bit        fend;
} head_result_t;

// stencil predictor plus the queue of results it still waits for
class head_scoreboard;
  bit [31:0] thick = 32'd65536;
  bit [31:0] t_area = 32'd65536;
  bit [15:0] n_rows = 16'd1024;
  bit [10:0] n_cols = 11'd1024;
  bit [31:0] up_head [gwh_pkg::MAX_COLS];
  bit [31:0] up_cond [gwh_pkg::MAX_COLS];
  bit [31:0] ctr_head [gwh_pkg::MAX_COLS];
  bit [31:0] ctr_cond [gwh_pkg::MAX_COLS];
  bit [15:0] ctr_yld [gwh_pkg::MAX_COLS];
  bit [31:0] ctr_src [gwh_pkg::MAX_COLS];
  int unsigned row_idx = 0;
  int unsigned col_idx = 0;
  head_result_t pending_heads[$];
  int fails = 0;

  function new();
    foreach (up_head[i]) begin
      up_head[i] = 0; up_cond[i] = 0; ctr_head[i] = 0;
      ctr_cond[i] = 0; ctr_yld[i] = 0; ctr_src[i] = 0;
    end
  endfunction

  function void write_reg(bit [1:0] idx, bit [31:0] data);
    case (idx)
      gwh_pkg::CFG_THICKNESS: thick = data;
      gwh_pkg::CFG_TIME_AREA: t_area = data;
      gwh_pkg::CFG_ROWS:      n_rows = data[15:0];
      gwh_pkg::CFG_COLS:      n_cols = data[10:0];
    endcase
  endfunction

  // truncated (h_n - h) * T term, T = K * thickness >> 32
  function longint flux(longint hn, longint h, bit [31:0] kn);
    bit [63:0] t;
    bit [63:0] mag;
    longint diff;
    t = ({32'b0, kn} * {32'b0, thick}) >> 32;
    diff = hn - h;
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    mag = (mag * t) >> 16;
    return (diff < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function void push(bit [31:0] head, bit fault, bit last, bit fend);
    head_result_t e;
    e.head = head; e.fault = fault; e.last = last; e.fend = fend;
    pending_heads.push_back(e);
  endfunction

  // expected results caused by one accepted cell beat
  function void predict_cell(bit [31:0] ih, bit [31:0] ik, bit [15:0] iy, bit [31:0] is);
    int unsigned rows, cols, r, c;
    bit last_col, last_row;
    longint h, q, nh;
    bit [127:0] prod, quo;
    bit [63:0] mag, a;
    rows = (n_rows < 3) ? 3 : n_rows;
    cols = (n_cols < 1) ? 1 : ((n_cols > gwh_pkg::MAX_COLS) ? gwh_pkg::MAX_COLS : n_cols);
    r = row_idx;
    c = col_idx;
    last_col = c >= cols - 1;
    last_row = r >= rows - 1;
    if (c >= gwh_pkg::MAX_COLS) c = gwh_pkg::MAX_COLS - 1;
    if (r == 0) begin
      push(ih, 1'b0, 1'b1, 1'b0);
    end else if (r >= 2) begin
      h = longint'(signed'(ctr_head[c]));
      if (ctr_yld[c] == 0) begin
        push(ctr_head[c], 1'b1, !last_row, 1'b0);
      end else begin
        q = flux(longint'(signed'(up_head[c])), h, up_cond[c]);
        if (c > 0) q += flux(longint'(signed'(up_head[c-1])), h, up_cond[c-1]);
        q += flux(longint'(signed'(ih)), h, ik);
        if (!last_col && c + 1 < gwh_pkg::MAX_COLS)
          q += flux(longint'(signed'(ctr_head[c+1])), h, ctr_cond[c+1]);
        q -= longint'(signed'(ctr_src[c]));
        a = (q < 0) ? 64'(-q) : 64'(q);
        prod = {64'b0, a} * {96'b0, t_area};
        quo = prod / {112'b0, ctr_yld[c]};
        mag = (quo > (128'd1 << 33)) ? (64'd1 << 33) : quo[63:0];
        nh = (q < 0) ? h - longint'(mag) : h + longint'(mag);
        if (nh > 64'sh7FFFFFFF) nh = 64'sh7FFFFFFF;
        if (nh < -64'sh80000000) nh = -64'sh80000000;
        push(nh[31:0], 1'b0, !last_row, 1'b0);
      end
      if (last_row) push(ih, 1'b0, 1'b1, last_col);
    end
    // column shift: center row moves up, new cell becomes center
    up_head[c] = ctr_head[c];
    up_cond[c] = ctr_cond[c];
    ctr_head[c] = ih;
    ctr_cond[c] = ik;
    ctr_yld[c] = iy;
    ctr_src[c] = is;
    if (last_col) begin
      col_idx = 0;
      row_idx = last_row ? 0 : ((r + 1) & 32'hFFFF);
    end else begin
      col_idx = c + 1;
    end
  endfunction

  function void check_result(bit [31:0] head, bit fault, bit last, bit fend);
    head_result_t e;
    if (pending_heads.size() == 0) begin
      $display("%0t: unexpected result beat head=%h fault=%b last=%b fend=%b",
               $time, head, fault, last, fend);
      fails++;
      return;
    end
    e = pending_heads.pop_front();
    if (head !== e.head) begin
      $display("%0t: head_out expected %h actual %h", $time, e.head, head);
      fails++;
    end
    if (fault !== e.fault) begin
      $display("%0t: yield_fault expected %b actual %b", $time, e.fault, fault);
      fails++;
    end
    if (last !== e.last) begin
      $display("%0t: last_of_run expected %b actual %b", $time, e.last, last);
      fails++;
    end
    if (fend !== e.fend) begin
      $display("%0t: frame_end expected %b actual %b", $time, e.fend, fend);
      fails++;
    end
  endfunction

  function int pending();
    return pending_heads.size();
  endfunction
endclass

module tb_top;
  import gwh_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 200;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;   // cell_head, conductivity, specific_yield, source_flow
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;       // head_out
  logic         out_tlast;
  logic [1:0]   out_tuser;       // yield_fault, frame_end
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  head_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int cells_sent = 0;

  groundwater_head_stencil_update dut (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser[0], out_tlast, out_tuser[1]);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one register write beat, valid left high for the caller to drop
  task automatic cfg_write(bit [1:0] idx, bit [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // stop sending, wait for the block to drain, then load all four registers
  task automatic load_regs(bit [31:0] thk, bit [31:0] ta, bit [31:0] rows, bit [31:0] cols);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write(CFG_THICKNESS, thk);
    cfg_write(CFG_TIME_AREA, ta);
    cfg_write(CFG_ROWS, rows);
    cfg_write(CFG_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  // one cell beat, with random idle cycles ahead of it
  task automatic send_cell(bit [31:0] h, bit [31:0] k, bit [15:0] y, bit [31:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s, y, k, h};
    do @(posedge clk); while (!in_tready);
    sb.predict_cell(h, k, y, s);
    cells_sent++;
  endtask

  function automatic bit [31:0] pick_head();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(32'h40000)) - 32'h20000;
    endcase
  endfunction

  function automatic bit [31:0] pick_cond();
    case ($urandom_range(4))
      0: return 32'hFFFFFFFF;
      1: return 32'h0;
      2: return $urandom;
      default: return $urandom_range(32'h10000000);
    endcase
  endfunction

  function automatic bit [15:0] pick_yield();
    case ($urandom_range(7))
      0: return 16'h0;
      1: return 16'hFFFF;
      2: return $urandom_range(16);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [31:0] pick_src();
    case ($urandom_range(4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($urandom_range(32'h2000)) - 32'h1000;
    endcase
  endfunction

  function automatic bit [31:0] pick_scale();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'd65536;
      3: return $urandom;
      default: return $urandom_range(32'h20000);
    endcase
  endfunction

  initial begin
    int phase, n_items, pause_at;
    bit [31:0] rows, cols;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes on a 3x3 frame, then a 3x2 frame with mixed scaling
    load_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd3, 32'd3);
    send_cell(32'h7FFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 32'h7FFFFFFF);
    send_cell(32'h80000000, 32'hFFFFFFFF, 16'h0000, 32'h80000000);
    send_cell(32'h00000000, 32'h00000000, 16'h0001, 32'h00000000);
    send_cell(32'h80000000, 32'hFFFFFFFF, 16'h0001, 32'h80000000);
    send_cell(32'h7FFFFFFF, 32'hFFFFFFFF, 16'h0000, 32'h7FFFFFFF);
    send_cell(32'h00010000, 32'h80000000, 16'hFFFF, 32'h00000000);
    send_cell(32'h7FFFFFFF, 32'hFFFFFFFF, 16'h0001, 32'h7FFFFFFF);
    send_cell(32'h80000000, 32'hFFFFFFFF, 16'h0001, 32'h80000000);
    send_cell(32'h00000000, 32'h00000000, 16'h8000, 32'h00000000);
    load_regs(32'd65536, 32'd65536, 32'd0, 32'd2);
    send_cell(32'h00020000, 32'h10000000, 16'h8000, 32'h00001000);
    send_cell(32'hFFFE0000, 32'h20000000, 16'h4000, 32'hFFFFF000);
    send_cell(32'h00010000, 32'h40000000, 16'h1000, 32'h00000000);
    send_cell(32'h00000000, 32'h40000000, 16'h0000, 32'h00010000);
    send_cell(32'h00050000, 32'hFFFFFFFF, 16'hFFFF, 32'h0000FFFF);
    send_cell(32'hFFFB0000, 32'h00000001, 16'h0001, 32'h7FFFFFFF);
    // single column, rows below three act as three
    load_regs(32'h0, 32'hFFFFFFFF, 32'd1, 32'd0);
    send_cell(32'h00030000, 32'hFFFFFFFF, 16'h0002, 32'h00000100);
    send_cell(32'h00010000, 32'hFFFFFFFF, 16'h0002, 32'h80000000);
    send_cell(32'hFFFF0000, 32'h00000000, 16'h0002, 32'h00000000);

    // random phases: config, idling mode and a run of cells
    phase = 0;
    while (cells_sent < 1880) begin
      case ($urandom_range(9))
        0: rows = 32'd65535;
        1: rows = $urandom_range(2);
        default: rows = $urandom_range(3, 7);
      endcase
      case ($urandom_range(11))
        0: cols = 32'd1024;
        1: cols = $urandom_range(1025, 2047);
        2: cols = 32'd0;
        3: cols = 32'd1;
        default: cols = $urandom_range(2, 9);
      endcase
      load_regs(pick_scale(), pick_scale(), rows, cols);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      n_items = $urandom_range(30, 110);
      pause_at = (phase % 5 == 3) ? n_items / 2 : -1;
      for (int i = 0; i < n_items; i++) begin
        // hold off until every expected result is back
        if (i == pause_at) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        send_cell(pick_head(), pick_cond(), pick_yield(), pick_src());
      end
      phase++;
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
